[rtl/core/dtw_ca_pkg.sv]
// Shared types and register indexes for the DTW cost accumulator.
`default_nettype none

package dtw_ca_pkg;

  // Configuration register indexes
  localparam logic [7:0] REG_NUM_ROWS = 8'd0;
  localparam logic [7:0] REG_NUM_COLS = 8'd1;

  // Width of the grid size registers
  localparam int SIZE_W = 11;

  // Position flags of a cell in the compute stage
  typedef struct packed {
    logic first_row;  // no neighbor above
    logic first_col;  // no neighbor to the left
    logic last;       // final cell of the grid
    logic fwd;        // take the cell above from the bypass register
  } cell_flags_t;

endpackage

`default_nettype wire

[rtl/core/dtw_ca_row_mem.sv]
// Row buffer memory: one write port, one read port with registered read data.
`default_nettype none

module dtw_ca_row_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write back the finished cost
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the entry above, hold the data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/dtw_ca_cell_calc.sv]
// Cell update: minimum of the neighbors, add the local cost, saturate.
`default_nettype none

module dtw_ca_cell_calc #(
  parameter int COST_WIDTH = 16,
  parameter int ACC_WIDTH  = 32
) (
  input  wire logic [COST_WIDTH-1:0]    cost,
  input  wire logic [ACC_WIDTH-1:0]     above,
  input  wire logic [ACC_WIDTH-1:0]     left,
  input  wire logic [ACC_WIDTH-1:0]     diag,
  input  dtw_ca_pkg::cell_flags_t       flags,
  output logic      [ACC_WIDTH-1:0]     sum,
  output logic                          sat
);
  import dtw_ca_pkg::*;

  localparam int SUM_W = ((ACC_WIDTH > COST_WIDTH) ? ACC_WIDTH : COST_WIDTH) + 1;
  localparam logic [SUM_W-1:0] ACC_MAX = SUM_W'({ACC_WIDTH{1'b1}});

  logic [ACC_WIDTH-1:0] min_al;
  logic [ACC_WIDTH-1:0] best;
  logic [SUM_W-1:0]     raw;

  // Pick the cheapest available neighbor
  always_comb begin
    min_al = (above < left) ? above : left;
    if (flags.first_row && flags.first_col) begin
      best = '0;
    end else if (flags.first_row) begin
      best = left;
    end else if (flags.first_col) begin
      best = above;
    end else begin
      best = (min_al < diag) ? min_al : diag;
    end
  end

  // Add and clip at the top of the accumulator range
  always_comb begin
    raw = SUM_W'(cost) + SUM_W'(best);
    sat = (raw > ACC_MAX);
    sum = sat ? {ACC_WIDTH{1'b1}} : ACC_WIDTH'(raw);
  end

endmodule

`default_nettype wire

[rtl/core/dtw_cost_accumulator.sv]
// DTW cost accumulator: compute stage register, then output register. Throughput one
// word per cycle unless res_ready stalls; the row buffer is read on accept and written
// on fire, with a bypass when the same column follows directly (one column).
// Synchronous reset sets the grid to 1 by 1 and the position to the origin;
// the row buffer is not cleared, each entry is written on a row before it is read.
`default_nettype none

module dtw_cost_accumulator #(
  parameter int MAX_LEN    = 1024,
  parameter int COST_WIDTH = 16,
  parameter int ACC_WIDTH  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  // local cost words
  input  wire logic        cell_valid,
  output logic             cell_ready,
  input  wire logic [15:0] local_cost,
  // accumulated cost words
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [31:0]      acc_cost,
  output logic [9:0]       row_index,
  output logic [9:0]       col_index,
  output logic             last_cell,
  output logic             saturated
);
  import dtw_ca_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN);

  logic [SIZE_W-1:0]     num_rows;
  logic [SIZE_W-1:0]     num_cols;
  logic [CNT_W-1:0]      last_row;
  logic [CNT_W-1:0]      last_col;
  logic [CNT_W-1:0]      row_cnt;
  logic [CNT_W-1:0]      col_cnt;

  logic                  s1_valid;
  logic [COST_WIDTH-1:0] s1_cost;
  logic [CNT_W-1:0]      s1_row;
  logic [CNT_W-1:0]      s1_col;
  cell_flags_t           s1_flags;
  logic [ACC_WIDTH-1:0]  fwd_data;

  logic [ACC_WIDTH-1:0]  left_cost;
  logic [ACC_WIDTH-1:0]  diag_cost;

  logic                  accept;
  logic                  fire;
  logic                  cfg_wr;
  logic                  at_last_col;
  logic                  at_last_row;
  logic [ACC_WIDTH-1:0]  rd_data;
  logic [ACC_WIDTH-1:0]  above;
  logic [ACC_WIDTH-1:0]  sum;
  logic                  sat;

  // Handshakes
  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign fire       = s1_valid && (!res_valid || res_ready);
  assign cell_ready = !s1_valid || fire;
  assign accept     = cell_valid && cell_ready;

  // Clamp the grid sizes to 1..MAX_LEN and keep the last index
  always_comb begin
    if (num_rows == '0) begin
      last_row = '0;
    end else if (32'(num_rows) > 32'(MAX_LEN)) begin
      last_row = CNT_W'(MAX_LEN - 1);
    end else begin
      last_row = CNT_W'(num_rows - SIZE_W'(1));
    end
    if (num_cols == '0) begin
      last_col = '0;
    end else if (32'(num_cols) > 32'(MAX_LEN)) begin
      last_col = CNT_W'(MAX_LEN - 1);
    end else begin
      last_col = CNT_W'(num_cols - SIZE_W'(1));
    end
  end

  assign at_last_col = (col_cnt == last_col);
  assign at_last_row = (row_cnt == last_row);

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= SIZE_W'(1);
      num_cols <= SIZE_W'(1);
    end else if (cfg_wr) begin
      if (cfg_index == REG_NUM_ROWS) begin
        num_rows <= cfg_data;
      end else if (cfg_index == REG_NUM_COLS) begin
        num_cols <= cfg_data;
      end
    end
  end

  // Advance the grid position on each accepted word, restart on a size write
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (cfg_wr && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS)) begin
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      if (at_last_col) begin
        col_cnt <= '0;
        row_cnt <= at_last_row ? '0 : row_cnt + CNT_W'(1);
      end else begin
        col_cnt <= col_cnt + CNT_W'(1);
      end
    end
  end

  // Compute stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the word, its position and the bypass decision
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cost            <= COST_WIDTH'(local_cost);
      s1_row             <= row_cnt;
      s1_col             <= col_cnt;
      s1_flags.first_row <= (row_cnt == '0);
      s1_flags.first_col <= (col_cnt == '0);
      s1_flags.last      <= at_last_col && at_last_row;
      s1_flags.fwd       <= fire && (s1_col == col_cnt);
      fwd_data           <= sum;
    end
  end

  dtw_ca_row_mem #(
    .DEPTH (MAX_LEN),
    .WIDTH (ACC_WIDTH)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (fire),
    .wr_addr (s1_col),
    .wr_data (sum),
    .rd_en   (accept),
    .rd_addr (col_cnt),
    .rd_data (rd_data)
  );

  // Cell above: zero on the first row, bypass when just written
  always_comb begin
    if (s1_flags.first_row) begin
      above = '0;
    end else if (s1_flags.fwd) begin
      above = fwd_data;
    end else begin
      above = rd_data;
    end
  end

  dtw_ca_cell_calc #(
    .COST_WIDTH (COST_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_cell_calc (
    .cost  (s1_cost),
    .above (above),
    .left  (left_cost),
    .diag  (diag_cost),
    .flags (s1_flags),
    .sum   (sum),
    .sat   (sat)
  );

  // Update the left and diagonal neighbors
  always_ff @(posedge clk) begin
    if (rst) begin
      left_cost <= '0;
      diag_cost <= '0;
    end else if (fire) begin
      left_cost <= sum;
      diag_cost <= above;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      acc_cost  <= 32'(sum);
      row_index <= 10'(s1_row);
      col_index <= 10'(s1_col);
      last_cell <= s1_flags.last;
      saturated <= sat;
    end
  end

endmodule

`default_nettype wire

[tb/tb_dtw_cost_accumulator.sv]
// Self-checking testbench for the DTW cost accumulator: grid walks, size limits, stalls.
`timescale 1ns / 1ps

module tb_dtw_cost_accumulator;
  import dtw_ca_pkg::*;

  localparam int          MAX_LEN       = 1024;
  localparam int          RANDOM_ITEMS  = 120;
  localparam int          TALL_ITEMS    = 40;
  localparam int          LONG_HOLD     = 100;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          TAIL_CYCLES   = 16;
  localparam int          MAX_REPORTS   = 10;
  localparam logic [7:0]  REG_UNUSED_LO = REG_NUM_COLS + 8'd1;
  localparam logic [7:0]  REG_UNUSED_HI = 8'hFF;

  typedef struct {
    logic [31:0] acc;
    logic [9:0]  row;
    logic [9:0]  col;
    logic        last;
    logic        sat;
  } cell_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_index;
  logic [SIZE_W-1:0] cfg_data;
  logic              cell_valid;
  logic              cell_ready;
  logic [15:0]       local_cost;
  logic              res_valid;
  logic              res_ready;
  logic [31:0]       acc_cost;
  logic [9:0]        row_index;
  logic [9:0]        col_index;
  logic              last_cell;
  logic              saturated;

  // Predictor state: grid size, row buffer, neighbors and position
  logic [SIZE_W-1:0] grid_rows;
  logic [SIZE_W-1:0] grid_cols;
  logic [31:0]       row_acc [0:MAX_LEN-1];
  logic [31:0]       left_acc;
  logic [31:0]       diag_acc;
  int unsigned       next_row;
  int unsigned       next_col;

  cell_result_t      cost_pending [$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  bit                burst_mode;
  bit                cell_offering;
  int                hold_req;
  int                hold_seen = 0;

  dtw_cost_accumulator u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_valid (cell_valid),
    .cell_ready (cell_ready),
    .local_cost (local_cost),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .acc_cost   (acc_cost),
    .row_index  (row_index),
    .col_index  (col_index),
    .last_cell  (last_cell),
    .saturated  (saturated)
  );

  always #4 clk = ~clk;

  // Map a size register to the grid extent it stands for
  function automatic int unsigned grid_extent(logic [SIZE_W-1:0] value);
    if (value == 0) return 1;
    if (value > MAX_LEN) return MAX_LEN;
    return value;
  endfunction

  // Apply a register write; a known index restarts the grid at the origin
  function automatic void apply_register(logic [7:0] idx, logic [SIZE_W-1:0] value);
    if (idx == REG_NUM_ROWS) grid_rows = value;
    else if (idx == REG_NUM_COLS) grid_cols = value;
    else return;
    next_row = 0;
    next_col = 0;
  endfunction

  // Accumulate one cell: local cost plus the cheapest available neighbor
  function automatic cell_result_t accumulate_cell(logic [15:0] cost);
    logic [31:0]  above;
    logic [31:0]  best;
    logic [32:0]  total;
    cell_result_t r;
    above = (next_row > 0) ? row_acc[next_col] : 32'd0;
    if (next_row == 0 && next_col == 0) begin
      best = 32'd0;
    end else if (next_row == 0) begin
      best = left_acc;
    end else if (next_col == 0) begin
      best = above;
    end else begin
      best = (above < left_acc) ? above : left_acc;
      if (diag_acc < best) best = diag_acc;
    end
    // clip at the top of the accumulator; unreachable with 16-bit costs on a 1024 grid
    total  = {1'b0, best} + {17'd0, cost};
    r.sat  = total[32];
    r.acc  = total[32] ? 32'hFFFF_FFFF : total[31:0];
    r.row  = next_row[9:0];
    r.col  = next_col[9:0];
    r.last = 1'b0;
    diag_acc = above;
    left_acc = r.acc;
    row_acc[next_col] = r.acc;
    // advance in row-major order, wrap after the final cell
    if (next_col + 1 >= grid_extent(grid_cols)) begin
      next_col = 0;
      if (next_row + 1 >= grid_extent(grid_rows)) begin
        next_row = 0;
        r.last   = 1'b1;
      end else begin
        next_row++;
      end
    end else begin
      next_col++;
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none in burst mode
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Costs with extremes and many small values so that neighbors tie
  function automatic logic [15:0] pick_cost();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Mostly small sizes, sometimes zero or beyond the row buffer
  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 99) < 85) return SIZE_W'($urandom_range(1, 12));
    case ($urandom_range(0, 4))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd1024;
      3: return 11'd1025;
      default: return 11'h7FF;
    endcase
  endfunction

  task automatic flag_mismatch(string field, cell_result_t want, logic [31:0] exp_v,
                               logic [31:0] got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at cell (%0d,%0d) %s: expected %h, got %h",
               want.row, want.col, field, exp_v, got_v);
  endtask

  // Send one cost word; valid stays high on return until the next word or a settle
  task automatic send_cost(logic [15:0] cost);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (cell_offering) cell_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_valid    <= 1'b1;
    local_cost    <= cost;
    cell_offering  = 1'b1;
    @(posedge clk);
    while (!cell_ready) @(posedge clk);
    cost_pending.insert(cost_pending.size(), accumulate_cell(cost));
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic settle_grid();
    if (cell_offering) begin
      cell_valid   <= 1'b0;
      cell_offering = 1'b0;
    end
    while (cost_pending.size() != 0) @(posedge clk);
  endtask

  // Write one register; chain keeps valid high for a following write
  task automatic cfg_write(logic [7:0] idx, logic [SIZE_W-1:0] value, bit chain);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_register(idx, value);
    if (!chain) cfg_valid <= 1'b0;
  endtask

  task automatic set_grid(logic [SIZE_W-1:0] rows, logic [SIZE_W-1:0] cols);
    settle_grid();
    cfg_write(REG_NUM_ROWS, rows, 1'b1);
    cfg_write(REG_NUM_COLS, cols, 1'b0);
  endtask

  // Grid out of reset is 1 by 1: every word is an origin and a final cell
  task automatic test_reset_default();
    send_cost(16'hFFFF);
    send_cost(16'h0000);
  endtask

  // First row, first column, interior minimum and final cell with extreme costs
  task automatic test_corner_grid();
    logic [15:0] corner_costs [0:11];
    corner_costs = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                     16'h5555, 16'hAAAA, 16'h0000, 16'h7FFF,
                     16'hFFFF, 16'h0002, 16'h0000, 16'hFFFF};
    set_grid(11'd3, 11'd4);
    for (int k = 0; k < 12; k++) send_cost(corner_costs[k]);
  endtask

  // Zero sizes act as one
  task automatic test_zero_size();
    set_grid(11'd0, 11'd0);
    for (int k = 0; k < 3; k++) send_cost(pick_cost());
  endtask

  // Writes to unknown indexes neither change the grid nor restart it
  task automatic test_ignored_index();
    set_grid(11'd2, 11'd2);
    send_cost(16'h1234);
    settle_grid();
    cfg_write(REG_UNUSED_LO, 11'd7, 1'b1);
    cfg_write(REG_UNUSED_HI, 11'h7FF, 1'b0);
    for (int k = 0; k < 3; k++) send_cost(pick_cost());
  endtask

  // One row as wide as the buffer allows, past the final cell into the next grid
  task automatic test_wide_row();
    set_grid(11'd1, 11'd1025);
    for (int k = 0; k < MAX_LEN + 1; k++) send_cost(pick_cost());
  endtask

  // Single column back to back: each cell reads the one written just before
  task automatic test_tall_column();
    set_grid(11'h7FF, 11'd1);
    burst_mode = 1'b1;
    for (int k = 0; k < TALL_ITEMS; k++) send_cost(pick_cost());
    burst_mode = 1'b0;
  endtask

  // Hold the result side so the block fills, then pause the sender until empty
  task automatic test_backpressure();
    set_grid(11'd4, 11'd6);
    hold_req++;
    while (hold_seen != hold_req) @(posedge clk);
    burst_mode = 1'b1;
    for (int k = 0; k < 40; k++) send_cost(pick_cost());
    burst_mode = 1'b0;
    settle_grid();
    for (int k = 0; k < 12; k++) send_cost(pick_cost());
  endtask

  // Random grid sizes, one or both registers rewritten, full and partial grids
  task automatic test_random_grids();
    int unsigned sent;
    int unsigned count;
    int unsigned area;
    int unsigned mode;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle_grid();
      mode = $urandom_range(0, 3);
      if (mode == 0) begin
        cfg_write(REG_NUM_ROWS, pick_size(), 1'b0);
      end else if (mode == 1) begin
        cfg_write(REG_NUM_COLS, pick_size(), 1'b0);
      end else begin
        cfg_write(REG_NUM_ROWS, pick_size(), 1'b1);
        cfg_write(REG_NUM_COLS, pick_size(), 1'b0);
      end
      area = grid_extent(grid_rows) * grid_extent(grid_cols);
      if (area <= 40 && $urandom_range(0, 1)) count = area;
      else count = $urandom_range(1, (area <= 40) ? 2 * area : 60);
      burst_mode = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < count; k++) send_cost(pick_cost());
      sent += count;
    end
    burst_mode = 1'b0;
  endtask

  // Drive result ready: random runs and stalls, a long hold on request
  initial begin : ready_driver
    int unsigned pick;
    int unsigned span;
    res_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_seen != hold_req) begin
        hold_seen  = hold_req;
        res_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          res_ready <= 1'b1;
          span = $urandom_range(1, 20);
        end else if (pick < 92) begin
          res_ready <= 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          res_ready <= 1'b0;
          span = $urandom_range(8, 40);
        end
        repeat (span) @(posedge clk);
      end
    end
  end

  // Compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (!rst && res_valid && res_ready) begin
      if (cost_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result at cell (%0d,%0d) with nothing pending", row_index, col_index);
      end else begin
        want = cost_pending.pop_front();
        if (acc_cost !== want.acc) flag_mismatch("acc_cost", want, want.acc, acc_cost);
        if (row_index !== want.row) flag_mismatch("row_index", want, want.row, row_index);
        if (col_index !== want.col) flag_mismatch("col_index", want, want.col, col_index);
        if (last_cell !== want.last) flag_mismatch("last_cell", want, want.last, last_cell);
        if (saturated !== want.sat) flag_mismatch("saturated", want, want.sat, saturated);
      end
    end
  end

  // End the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (cell_valid && cell_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = 8'd0;
    cfg_data      = '0;
    cell_valid    = 1'b0;
    local_cost    = 16'd0;
    grid_rows     = 11'd1;
    grid_cols     = 11'd1;
    left_acc      = 32'd0;
    diag_acc      = 32'd0;
    next_row      = 0;
    next_col      = 0;
    burst_mode    = 1'b0;
    cell_offering = 1'b0;
    hold_req      = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_reset_default();
    test_corner_grid();
    test_zero_size();
    test_ignored_index();
    test_wide_row();
    test_tall_column();
    test_backpressure();
    test_random_grids();

    settle_grid();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && cost_pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
